// File: rtl/rcmr_pkg.sv
// rcmr_pkg: shared constants, register codes and word types for roi_color_match_ratio.
// No dependencies.
package rcmr_pkg;

    localparam int MAX_FRAME_WIDTH  = 4096;
    localparam int MAX_FRAME_HEIGHT = 4096;
    localparam int RATIO_FRAC_BITS  = 16;

    // fixed field widths
    localparam int PIX_W   = 12;
    localparam int WIN_W   = 13;
    localparam int COLOR_W = 32;
    localparam int THR_W   = 8;
    localparam int COUNT_W = 25;
    localparam int CHANNELS = 4;
    localparam int CHAN_W  = 8;

    localparam int RATIO_W = RATIO_FRAC_BITS + 1;

    // coordinate width able to hold a register value and either frame limit
    localparam int XLIM_W  = $clog2(MAX_FRAME_WIDTH + 1);
    localparam int YLIM_W  = $clog2(MAX_FRAME_HEIGHT + 1);
    localparam int XY_W    = (XLIM_W > YLIM_W) ? XLIM_W : YLIM_W;
    localparam int SPAN_W  = (XY_W > WIN_W) ? XY_W : WIN_W;

    localparam int AREA_W  = $clog2(MAX_FRAME_WIDTH * MAX_FRAME_HEIGHT + 1);
    localparam int CMP_W   = (AREA_W > COUNT_W) ? AREA_W : COUNT_W;
    localparam int STEP_W  = $clog2(RATIO_FRAC_BITS + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [RATIO_W-1:0] RATIO_ONE = {1'b1, {RATIO_FRAC_BITS{1'b0}}};

    // frame-end queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_X_START   = 3'd0,
        REG_X_END     = 3'd1,
        REG_Y_START   = 3'd2,
        REG_Y_END     = 3'd3,
        REG_REF_COLOR = 3'd4,
        REG_THRESHOLD = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [WIN_W-1:0]   x_start;
        logic [WIN_W-1:0]   x_end;
        logic [WIN_W-1:0]   y_start;
        logic [WIN_W-1:0]   y_end;
        logic [COLOR_W-1:0] ref_color;
        logic [THR_W-1:0]   threshold;
    } cfg_t;

    // one finished frame waiting for the divider
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [AREA_W-1:0]  area;
        logic               empty;
    } frame_word_t;

endpackage

// File: rtl/roi_color_match_ratio.sv
// roi_color_match_ratio: top level; register file, pixel front end, frame queue, divider.
// Depends on rcmr_pkg, rcmr_cfg, rcmr_front, rcmr_queue, rcmr_div.
//
// Usage:
//   Pixel channel (pixel_valid / pixel_stall): one word per pixel with its x, y,
//   RGBA color and frame_last. A word moves when valid is high and stall is low.
//   Result channel (result_valid / result_stall): one word per frame carrying the
//   match count, the region area, the Q1.16 ratio and the empty-region flag.
//   Configuration goes through the APB port (registers at byte address 4*i); pready
//   is tied high and writes are expected only while the block is idle.
// Throughput: one pixel per clock. The divider is bit-serial, one quotient bit per cycle
//   over RATIO_FRAC_BITS steps, with a load state before and an output state after;
//   a two-deep queue of finished frames lets the pixel side keep running meanwhile,
//   so pixel_stall rises only when two frame ends are already waiting on the divider.
// Result path: the frame_last pixel passes the first-stage registers into the queue;
//   result_valid rises from the divider's idle state when the ratio is settled
//   without dividing (empty region or count >= area), else after the division steps.
// Reset: rst_n (asynchronous, active low) clears the registers to 0, the match
//   count, the queue and the divider. While result_stall is high the result word
//   holds; the divider and queue wait and pixels keep flowing until the queue fills.
module roi_color_match_ratio
    import rcmr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  logic [PIX_W-1:0]      pixel_x,
    input  logic [PIX_W-1:0]      pixel_y,
    input  logic [COLOR_W-1:0]    pixel_rgba,
    input  logic                  frame_last,

    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [COUNT_W-1:0]    match_count,
    output logic [COUNT_W-1:0]    area_pixels,
    output logic [RATIO_W-1:0]    match_ratio,
    output logic                  area_empty
);

    cfg_t              cfg;
    logic              push, pop, head_valid;
    frame_word_t       push_word, head_word;
    logic [QCNT_W-1:0] queue_count;

    rcmr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // front: test each pixel, count matches, post one word per frame end
    rcmr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_rgba  (pixel_rgba),
        .frame_last  (frame_last),
        .queue_count (queue_count),
        .push        (push),
        .push_word   (push_word)
    );

    rcmr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head_word (head_word),
        .not_empty (head_valid),
        .count     (queue_count)
    );

    // back: ratio division and the result register
    rcmr_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_word    (head_word),
        .head_valid   (head_valid),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .match_count  (match_count),
        .area_pixels  (area_pixels),
        .match_ratio  (match_ratio),
        .area_empty   (area_empty)
    );

endmodule

// File: rtl/rcmr_cfg.sv
// rcmr_cfg: APB register file holding the region and color settings.
// Depends on rcmr_pkg.
module rcmr_cfg
    import rcmr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       wr_en;

    assign index  = reg_index_t'(paddr[4:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (index)
                REG_X_START:   cfg_reg.x_start   <= pwdata[WIN_W-1:0];
                REG_X_END:     cfg_reg.x_end     <= pwdata[WIN_W-1:0];
                REG_Y_START:   cfg_reg.y_start   <= pwdata[WIN_W-1:0];
                REG_Y_END:     cfg_reg.y_end     <= pwdata[WIN_W-1:0];
                REG_REF_COLOR: cfg_reg.ref_color <= pwdata[COLOR_W-1:0];
                REG_THRESHOLD: cfg_reg.threshold <= pwdata[THR_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_X_START:   prdata = APB_DATA_W'(cfg_reg.x_start);
            REG_X_END:     prdata = APB_DATA_W'(cfg_reg.x_end);
            REG_Y_START:   prdata = APB_DATA_W'(cfg_reg.y_start);
            REG_Y_END:     prdata = APB_DATA_W'(cfg_reg.y_end);
            REG_REF_COLOR: prdata = APB_DATA_W'(cfg_reg.ref_color);
            REG_THRESHOLD: prdata = APB_DATA_W'(cfg_reg.threshold);
            default:       prdata = '0;
        endcase
    end

endmodule

// File: rtl/rcmr_front.sv
// rcmr_front: pixel intake, region and color test, per-frame match count, area.
// Depends on rcmr_pkg.
module rcmr_front
    import rcmr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               pixel_valid,
    output logic               pixel_stall,
    input  logic [PIX_W-1:0]   pixel_x,
    input  logic [PIX_W-1:0]   pixel_y,
    input  logic [COLOR_W-1:0] pixel_rgba,
    input  logic               frame_last,
    input  logic [QCNT_W-1:0]  queue_count,
    output logic               push,
    output frame_word_t        push_word
);

    localparam logic [SPAN_W-1:0] X_LIM = SPAN_W'(MAX_FRAME_WIDTH);
    localparam logic [SPAN_W-1:0] Y_LIM = SPAN_W'(MAX_FRAME_HEIGHT);

    logic [SPAN_W-1:0] xs, xe, ys, ye, xs_raw, xe_raw, ys_raw, ye_raw, px, py;
    logic              in_region, close, accept;
    logic [QCNT_W:0]   reserved;

    logic               s1_valid_reg, s1_match_reg, s1_last_reg;
    logic [COUNT_W-1:0] count_reg, count_next, count_inc;
    logic               empty;
    logic [SPAN_W-1:0]  dx, dy;
    logic [2*SPAN_W-1:0] product;

    // clamp the window to the frame
    assign xs_raw = SPAN_W'(cfg.x_start);
    assign xe_raw = SPAN_W'(cfg.x_end);
    assign ys_raw = SPAN_W'(cfg.y_start);
    assign ye_raw = SPAN_W'(cfg.y_end);
    assign xs = (xs_raw > X_LIM) ? X_LIM : xs_raw;
    assign xe = (xe_raw > X_LIM) ? X_LIM : xe_raw;
    assign ys = (ys_raw > Y_LIM) ? Y_LIM : ys_raw;
    assign ye = (ye_raw > Y_LIM) ? Y_LIM : ye_raw;

    assign px = SPAN_W'(pixel_x);
    assign py = SPAN_W'(pixel_y);
    assign in_region = (px >= xs) && (px < xe) && (py >= ys) && (py < ye);

    always_comb
    begin
        logic [CHAN_W-1:0] a, b, d;
        close = 1'b1;
        for (int c = 0; c < CHANNELS; c++)
        begin
            a = pixel_rgba[c*CHAN_W +: CHAN_W];
            b = cfg.ref_color[c*CHAN_W +: CHAN_W];
            d = (a > b) ? (a - b) : (b - a);
            if (d > cfg.threshold)
                close = 1'b0;
        end
    end

    // hold off while every queue slot is taken or promised to a frame end in flight
    assign reserved    = (QCNT_W+1)'(queue_count) + (QCNT_W+1)'(s1_valid_reg & s1_last_reg);
    assign pixel_stall = (reserved >= (QCNT_W+1)'(QUEUE_DEPTH));
    assign accept      = pixel_valid & ~pixel_stall;

    // second stage: count and close the frame
    assign count_inc  = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign count_next = (s1_valid_reg & s1_match_reg) ? count_inc : count_reg;

    assign empty   = !((xe > xs) && (ye > ys));
    assign dx      = xe - xs;
    assign dy      = ye - ys;
    assign product = dx * dy;

    assign push            = s1_valid_reg & s1_last_reg;
    assign push_word.count = count_next;
    assign push_word.area  = empty ? '0 : product[AREA_W-1:0];
    assign push_word.empty = empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_match_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_match_reg <= in_region & close;
            s1_last_reg  <= frame_last;
            if (s1_valid_reg)
                count_reg <= s1_last_reg ? '0 : count_next;
        end
    end

endmodule

// File: rtl/rcmr_queue.sv
// rcmr_queue: short register FIFO of finished frames between front and divider.
// Depends on rcmr_pkg.
module rcmr_queue
    import rcmr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  frame_word_t       push_word,
    input  logic              pop,
    output frame_word_t       head_word,
    output logic              not_empty,
    output logic [QCNT_W-1:0] count
);

    frame_word_t         mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign head_word = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

endmodule

// File: rtl/rcmr_div.sv
// rcmr_div: back end; bit-serial ratio divider and output register.
// Depends on rcmr_pkg.
module rcmr_div
    import rcmr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  frame_word_t        head_word,
    input  logic               head_valid,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [COUNT_W-1:0] match_count,
    output logic [COUNT_W-1:0] area_pixels,
    output logic [RATIO_W-1:0] match_ratio,
    output logic               area_empty
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                   state_reg, state_next;
    logic [AREA_W-1:0]        rem_reg, rem_next, area_reg;
    logic [RATIO_FRAC_BITS-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [COUNT_W-1:0]       count_reg, area_out_reg;
    logic [RATIO_W-1:0]       ratio_reg, ratio_next;
    logic                     empty_reg, valid_reg, valid_next;

    logic [AREA_W:0]          rem2;
    logic                     fits;
    logic [CMP_W-1:0]         head_count_ext, head_area_ext, count_max_ext;

    assign head_count_ext = CMP_W'(head_word.count);
    assign head_area_ext  = CMP_W'(head_word.area);
    assign count_max_ext  = CMP_W'(COUNT_MAX);

    // one restoring step: shift in a zero, subtract the area when it fits
    assign rem2 = {rem_reg, 1'b0};
    assign fits = (rem2 >= {1'b0, area_reg});

    assign pop = (state_reg == ST_IDLE) & head_valid;

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        ratio_next = ratio_reg;
        valid_next = valid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    rem_next  = head_word.count[AREA_W-1:0];
                    quo_next  = '0;
                    step_next = '0;
                    if (head_word.empty)
                    begin
                        ratio_next = '0;
                        valid_next = 1'b1;
                        state_next = ST_OUT;
                    end
                    else if (head_count_ext >= head_area_ext)
                    begin
                        ratio_next = RATIO_ONE;
                        valid_next = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        // count < area, so the remainder starts below the divisor
                        rem_next   = head_count_ext[AREA_W-1:0];
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next  = fits ? AREA_W'(rem2 - {1'b0, area_reg}) : rem2[AREA_W-1:0];
                quo_next  = {quo_reg[RATIO_FRAC_BITS-2:0], fits};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(RATIO_FRAC_BITS - 1))
                begin
                    ratio_next = RATIO_W'({quo_reg[RATIO_FRAC_BITS-2:0], fits});
                    valid_next = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!result_stall)
                begin
                    valid_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                valid_next = 1'b0;
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= 1'b0;
            rem_reg      <= '0;
            quo_reg      <= '0;
            step_reg     <= '0;
            ratio_reg    <= '0;
            area_reg     <= '0;
            count_reg    <= '0;
            area_out_reg <= '0;
            empty_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            step_reg  <= step_next;
            ratio_reg <= ratio_next;
            if (pop)
            begin
                area_reg     <= head_word.area;
                count_reg    <= head_word.count;
                empty_reg    <= head_word.empty;
                area_out_reg <= (head_area_ext > count_max_ext) ? COUNT_MAX
                                                                : head_area_ext[COUNT_W-1:0];
            end
        end
    end

    assign result_valid = valid_reg;
    assign match_count  = count_reg;
    assign area_pixels  = area_out_reg;
    assign match_ratio  = ratio_reg;
    assign area_empty   = empty_reg;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking testbench for roi_color_match_ratio, a pixel stream in and one
// summary word per frame out. Depends on rcmr_pkg and the block under rtl/.
module tb_top
    import rcmr_pkg::*;
;

    localparam int RESET_CYCLES  = 6;
    localparam int DRAIN_CYCLES  = 40;     // covers the divide plus pipeline slack
    localparam int QUIET_LIMIT   = 3000;   // cycles with no word moving on any port
    localparam int RANDOM_PIXELS = 1950;

    // register slots past the last defined register; writes there must be ignored
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam logic [WIN_W-1:0] X_LIM = WIN_W'(MAX_FRAME_WIDTH);
    localparam logic [WIN_W-1:0] Y_LIM = WIN_W'(MAX_FRAME_HEIGHT);

    typedef struct packed {
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic [COLOR_W-1:0] rgba;
        logic               last;
    } pixel_word_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] area;
        logic [RATIO_W-1:0] ratio;
        logic               empty;
    } frame_stats_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  pixel_valid;
    logic                  pixel_stall;
    logic [PIX_W-1:0]      pixel_x;
    logic [PIX_W-1:0]      pixel_y;
    logic [COLOR_W-1:0]    pixel_rgba;
    logic                  frame_last;
    logic                  result_valid;
    logic                  result_stall;
    logic [COUNT_W-1:0]    match_count;
    logic [COUNT_W-1:0]    area_pixels;
    logic [RATIO_W-1:0]    match_ratio;
    logic                  area_empty;

    // predictor state: its own copy of the registers and the running match count
    cfg_t               cfg_shadow;
    logic [COUNT_W-1:0] matches_running;
    frame_stats_t       frame_stats_due[$];   // expected summary words, oldest first
    frame_stats_t       stats_head;

    // stimulus side
    pixel_word_t pixels_pending[$];
    pixel_word_t next_pixel;
    logic        pixel_moved;
    int          pixel_gap;
    int          stall_left;
    int          pixel_idle_mode;
    int          result_stall_mode;
    int          quiet_cycles;

    // bookkeeping
    int mismatches;
    int pixels_sent;
    int frames_checked;
    int frames_empty;
    int frames_saturated;
    int setups_applied;

    roi_color_match_ratio u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_rgba   (pixel_rgba),
        .frame_last   (frame_last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .match_count  (match_count),
        .area_pixels  (area_pixels),
        .match_ratio  (match_ratio),
        .area_empty   (area_empty)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Predictor helpers
    // ------------------------------------------------------------------

    // window bounds beyond the frame are saturated to the frame size
    function automatic logic [WIN_W-1:0] clamp_bound(input logic [WIN_W-1:0] v,
                                                     input logic [WIN_W-1:0] lim);
        return (v > lim) ? lim : v;
    endfunction

    // all four channels, alpha too, within thr of the reference
    function automatic bit color_near(input logic [COLOR_W-1:0] px,
                                      input logic [COLOR_W-1:0] refc,
                                      input logic [THR_W-1:0]   thr);
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] d;
        for (int c = 0; c < CHANNELS; c++)
        begin
            a = px[c*CHAN_W +: CHAN_W];
            b = refc[c*CHAN_W +: CHAN_W];
            d = (a > b) ? a - b : b - a;
            if (d > thr)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // judges one accepted pixel word; on frame end queues the expected summary
    task automatic judge_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                               input logic [COLOR_W-1:0] rgba, input logic last);
        logic [WIN_W-1:0]                   xs;
        logic [WIN_W-1:0]                   xe;
        logic [WIN_W-1:0]                   ys;
        logic [WIN_W-1:0]                   ye;
        logic [AREA_W-1:0]                  span_x;
        logic [AREA_W-1:0]                  span_y;
        logic [AREA_W-1:0]                  area;
        logic [COUNT_W+RATIO_FRAC_BITS-1:0] num;
        logic [COUNT_W+RATIO_FRAC_BITS-1:0] quot;
        frame_stats_t                       s;
        xs = clamp_bound(cfg_shadow.x_start, X_LIM);
        xe = clamp_bound(cfg_shadow.x_end, X_LIM);
        ys = clamp_bound(cfg_shadow.y_start, Y_LIM);
        ye = clamp_bound(cfg_shadow.y_end, Y_LIM);
        if (x >= xs && x < xe && y >= ys && y < ye
            && color_near(rgba, cfg_shadow.ref_color, cfg_shadow.threshold)
            && matches_running != COUNT_MAX)
            matches_running = matches_running + 1'b1;
        if (last)
        begin
            s.count = matches_running;
            s.empty = !(xe > xs && ye > ys);
            s.ratio = '0;
            area    = '0;
            if (!s.empty)
            begin
                span_x = AREA_W'(xe - xs);
                span_y = AREA_W'(ye - ys);
                area   = span_x * span_y;
                num    = {matches_running, {RATIO_FRAC_BITS{1'b0}}};
                quot   = num / area;
                // more matches than area (repeated pixels) pins the ratio at one
                s.ratio = (quot > RATIO_ONE) ? RATIO_ONE : quot[RATIO_W-1:0];
                if (quot >= RATIO_ONE)
                    frames_saturated++;
            end
            else
                frames_empty++;
            s.area = (area > COUNT_MAX) ? COUNT_MAX : area;
            frame_stats_due.push_back(s);
            matches_running = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // register value as a read should return it
    function automatic logic [APB_DATA_W-1:0] shadow_reg(input logic [2:0] index);
        logic [APB_DATA_W-1:0] v;
        v = '0;
        case (index)
            REG_X_START:   v = APB_DATA_W'(cfg_shadow.x_start);
            REG_X_END:     v = APB_DATA_W'(cfg_shadow.x_end);
            REG_Y_START:   v = APB_DATA_W'(cfg_shadow.y_start);
            REG_Y_END:     v = APB_DATA_W'(cfg_shadow.y_end);
            REG_REF_COLOR: v = APB_DATA_W'(cfg_shadow.ref_color);
            REG_THRESHOLD: v = APB_DATA_W'(cfg_shadow.threshold);
            default:       v = '0;
        endcase
        return v;
    endfunction

    // mostly short gaps, a few long ones; mode 0 means back to back
    function automatic int idle_length(input int mode);
        int r;
        r = $urandom_range(99, 0);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return (r < 75) ? 0 : (r < 95) ? $urandom_range(3, 1) : $urandom_range(40, 8);
        return (r < 40) ? 0 : (r < 85) ? $urandom_range(4, 1) : $urandom_range(60, 10);
    endfunction

    // ------------------------------------------------------------------
    // Pixel driver: presents the next pending word at the falling edge,
    // holds it while stalled, and may idle for a random gap after each word.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!pixel_valid || pixel_moved))
        begin
            if (pixel_gap > 0 || pixels_pending.size() == 0)
            begin
                pixel_valid <= 1'b0;
                if (pixel_gap > 0)
                    pixel_gap <= pixel_gap - 1;
            end
            else
            begin
                next_pixel = pixels_pending.pop_front();
                pixel_x     <= next_pixel.x;
                pixel_y     <= next_pixel.y;
                pixel_rgba  <= next_pixel.rgba;
                frame_last  <= next_pixel.last;
                pixel_valid <= 1'b1;
                pixel_gap   <= idle_length(pixel_idle_mode);
            end
        end
    end

    // result side back-pressure: stall bursts, never back to back
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            result_stall <= 1'b0;
            stall_left   <= idle_length(result_stall_mode);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted pixel word goes to the predictor; every
    // accepted result word is checked field by field against the oldest
    // expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            pixel_moved <= pixel_valid && !pixel_stall;
            if (pixel_valid && !pixel_stall)
                judge_pixel(pixel_x, pixel_y, pixel_rgba, frame_last);
            if (result_valid && !result_stall)
            begin
                if (frame_stats_due.size() == 0)
                    report_mismatch("result word with nothing expected", 64'(match_count),
                                    64'(0));
                else
                begin
                    stats_head = frame_stats_due.pop_front();
                    frames_checked++;
                    if (match_count !== stats_head.count)
                        report_mismatch("match_count", 64'(match_count),
                                        64'(stats_head.count));
                    if (area_pixels !== stats_head.area)
                        report_mismatch("area_pixels", 64'(area_pixels),
                                        64'(stats_head.area));
                    if (match_ratio !== stats_head.ratio)
                        report_mismatch("match_ratio", 64'(match_ratio),
                                        64'(stats_head.ratio));
                    if (area_empty !== stats_head.empty)
                        report_mismatch("area_empty", 64'(area_empty),
                                        64'(stats_head.empty));
                end
            end
        end
    end

    // watchdog: any pixel, result or register access resets the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall)
                || (psel && penable))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: nothing moved for %0d cycles", QUIET_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Register port and stimulus tasks
    // ------------------------------------------------------------------

    // setup then access; the register takes the value at the end of access
    task automatic apb_write(input logic [2:0] index, input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_X_START:   cfg_shadow.x_start   = data[WIN_W-1:0];
            REG_X_END:     cfg_shadow.x_end     = data[WIN_W-1:0];
            REG_Y_START:   cfg_shadow.y_start   = data[WIN_W-1:0];
            REG_Y_END:     cfg_shadow.y_end     = data[WIN_W-1:0];
            REG_REF_COLOR: cfg_shadow.ref_color = data[COLOR_W-1:0];
            REG_THRESHOLD: cfg_shadow.threshold = data[THR_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic apb_check(input logic [2:0] index);
        logic [APB_DATA_W-1:0] want;
        want = shadow_reg(index);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {index, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
            report_mismatch("register read back", 64'(prdata), 64'(want));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // writes every register (upper bits of the word random), then reads them back
    task automatic apply_setup(input logic [WIN_W-1:0] xs, input logic [WIN_W-1:0] xe,
                               input logic [WIN_W-1:0] ys, input logic [WIN_W-1:0] ye,
                               input logic [COLOR_W-1:0] refc, input logic [THR_W-1:0] thr);
        logic [2:0] index;
        apb_write(REG_X_START, {19'($urandom_range(524287, 0)), xs});
        apb_write(REG_X_END, {19'($urandom_range(524287, 0)), xe});
        apb_write(REG_Y_START, {19'($urandom_range(524287, 0)), ys});
        apb_write(REG_Y_END, {19'($urandom_range(524287, 0)), ye});
        apb_write(REG_REF_COLOR, refc);
        apb_write(REG_THRESHOLD, {24'($urandom_range(16777215, 0)), thr});
        for (int i = 0; i < 6; i++)
        begin
            index = 3'(i);
            apb_check(index);
        end
        setups_applied++;
    endtask

    task automatic push_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                              input logic [COLOR_W-1:0] rgba, input logic last);
        pixel_word_t w;
        w.x    = x;
        w.y    = y;
        w.rgba = rgba;
        w.last = last;
        pixels_pending.push_back(w);
        pixels_sent++;
    endtask

    // sender holds off until every summary is in, then lets the divider settle
    task automatic wait_idle();
        while (pixels_pending.size() != 0 || pixel_valid)
            @(posedge clk);
        while (frame_stats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly inside the window and near the reference color, some on the
    // window edges, some pure noise
    task automatic push_random_pixel(input logic last);
        logic [WIN_W-1:0]   xs;
        logic [WIN_W-1:0]   xe;
        logic [WIN_W-1:0]   ys;
        logic [WIN_W-1:0]   ye;
        logic [WIN_W-1:0]   cx;
        logic [WIN_W-1:0]   cy;
        logic [COLOR_W-1:0] rgba;
        int                 r;
        int                 v;
        int                 d;
        xs = clamp_bound(cfg_shadow.x_start, X_LIM);
        xe = clamp_bound(cfg_shadow.x_end, X_LIM);
        ys = clamp_bound(cfg_shadow.y_start, Y_LIM);
        ye = clamp_bound(cfg_shadow.y_end, Y_LIM);
        r = $urandom_range(99, 0);
        if (r < 65 && xe > xs && ye > ys)
        begin
            cx = WIN_W'($urandom_range(xe - 1, xs));
            cy = WIN_W'($urandom_range(ye - 1, ys));
        end
        else if (r < 80)
        begin
            // one off either side of each bound
            case ($urandom_range(3, 0))
                0:       cx = xs - 1;
                1:       cx = xs;
                2:       cx = xe - 1;
                default: cx = xe;
            endcase
            case ($urandom_range(3, 0))
                0:       cy = ys - 1;
                1:       cy = ys;
                2:       cy = ye - 1;
                default: cy = ye;
            endcase
        end
        else
        begin
            cx = WIN_W'($urandom);
            cy = WIN_W'($urandom);
        end
        if ($urandom_range(99, 0) < 60)
        begin
            // each channel within threshold+1 of the reference, clipped to a byte
            for (int c = 0; c < CHANNELS; c++)
            begin
                d = $urandom_range(int'(cfg_shadow.threshold) + 1, 0);
                v = int'(cfg_shadow.ref_color[c*CHAN_W +: CHAN_W]);
                v = ($urandom_range(1, 0) == 1) ? v + d : v - d;
                v = (v < 0) ? 0 : (v > 255) ? 255 : v;
                rgba[c*CHAN_W +: CHAN_W] = CHAN_W'(v);
            end
        end
        else
            rgba = $urandom;
        push_pixel(cx[PIX_W-1:0], cy[PIX_W-1:0], rgba, last);
    endtask

    // a frame of random length; an open one carries its count into the next setup
    task automatic push_random_frame(input bit closed);
        int r;
        int len;
        r = $urandom_range(99, 0);
        len = (r < 80) ? $urandom_range(16, 1) : (r < 95) ? $urandom_range(60, 17)
                                                           : $urandom_range(200, 100);
        for (int i = 0; i < len; i++)
            push_random_pixel(closed && i == len - 1);
    endtask

    task automatic random_setup();
        logic [WIN_W-1:0]   xs;
        logic [WIN_W-1:0]   xe;
        logic [WIN_W-1:0]   ys;
        logic [WIN_W-1:0]   ye;
        logic [THR_W-1:0]   thr;
        int                 r;
        r = $urandom_range(99, 0);
        if (r < 50)
        begin
            // small region, so ratios are far from zero
            xs = WIN_W'($urandom_range(4095, 0));
            xe = xs + WIN_W'($urandom_range(6, 1));
            ys = WIN_W'($urandom_range(4095, 0));
            ye = ys + WIN_W'($urandom_range(6, 1));
        end
        else if (r < 60)
        begin
            xs = '0;
            xe = X_LIM;
            ys = '0;
            ye = Y_LIM;
        end
        else if (r < 70)
        begin
            // end bounds past the frame
            xs = WIN_W'($urandom_range(4095, 0));
            xe = WIN_W'($urandom_range(8191, 4097));
            ys = WIN_W'($urandom_range(4095, 4000));
            ye = WIN_W'($urandom_range(8191, 4097));
        end
        else if (r < 85)
        begin
            // empty or inverted in x
            xs = WIN_W'($urandom_range(8191, 0));
            xe = WIN_W'($urandom_range(xs, 0));
            ys = WIN_W'($urandom_range(8191, 0));
            ye = WIN_W'($urandom_range(8191, 0));
        end
        else
        begin
            xs = WIN_W'($urandom_range(8191, 0));
            xe = WIN_W'($urandom_range(8191, 0));
            ys = WIN_W'($urandom_range(8191, 0));
            ye = WIN_W'($urandom_range(8191, 0));
        end
        r = $urandom_range(99, 0);
        thr = (r < 20) ? 8'd0 : (r < 30) ? 8'd255 : THR_W'($urandom_range(40, 0));
        apply_setup(xs, xe, ys, ye, $urandom, thr);
        if ($urandom_range(3, 0) == 0)
            apb_write($urandom_range(1, 0) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        pixel_valid       = 1'b0;
        pixel_x           = '0;
        pixel_y           = '0;
        pixel_rgba        = '0;
        frame_last        = 1'b0;
        result_stall      = 1'b0;
        pixel_moved       = 1'b0;
        pixel_gap         = 0;
        stall_left        = 0;
        pixel_idle_mode   = 0;
        result_stall_mode = 0;
        quiet_cycles      = 0;
        mismatches        = 0;
        pixels_sent       = 0;
        frames_checked    = 0;
        frames_empty      = 0;
        frames_saturated  = 0;
        setups_applied    = 0;
        cfg_shadow        = '0;
        matches_running   = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // registers at reset: zero-size region, flag set and ratio 0
        push_pixel(12'd0, 12'd0, 32'h0000_0000, 1'b1);
        wait_idle();

        // ends past the frame clamp to the full frame; exact color only (threshold 0)
        apply_setup(13'd0, 13'h1FFF, 13'd0, 13'd5000, 32'hFFFF_FFFF, 8'd0);
        push_pixel(12'd4095, 12'd4095, 32'hFFFF_FFFF, 1'b0);
        push_pixel(12'd0, 12'd0, 32'hFFFF_FFFF, 1'b0);
        push_pixel(12'd0, 12'd0, 32'hFFFF_FFFE, 1'b0);
        push_pixel(12'd4095, 12'd0, 32'h0000_0000, 1'b1);
        wait_idle();

        // one-pixel region, any color: the neighbors stay out, the same pixel
        // three times drives the count past the area and the ratio to one
        pixel_idle_mode   = 2;
        result_stall_mode = 2;
        apply_setup(13'd10, 13'd11, 13'd20, 13'd21, 32'h8040_2010, 8'd255);
        push_pixel(12'd10, 12'd20, 32'h0000_0000, 1'b0);
        push_pixel(12'd10, 12'd20, 32'hFFFF_FFFF, 1'b0);
        push_pixel(12'd9, 12'd20, 32'h8040_2010, 1'b0);
        push_pixel(12'd11, 12'd20, 32'h8040_2010, 1'b0);
        push_pixel(12'd10, 12'd19, 32'h8040_2010, 1'b0);
        push_pixel(12'd10, 12'd21, 32'h8040_2010, 1'b0);
        push_pixel(12'd10, 12'd20, 32'h1234_5678, 1'b1);
        wait_idle();

        // threshold edge: a channel 4 away matches, 5 away (alpha or red) does not;
        // the frame stays open across the next register change
        apply_setup(13'd100, 13'd104, 13'd0, 13'd4, 32'h1010_1010, 8'd4);
        push_pixel(12'd100, 12'd0, 32'h1414_1414, 1'b0);
        push_pixel(12'd103, 12'd3, 32'h0C0C_0C0C, 1'b0);
        push_pixel(12'd101, 12'd1, 32'h1510_1010, 1'b0);
        push_pixel(12'd101, 12'd1, 32'h1010_100B, 1'b0);
        push_pixel(12'd104, 12'd0, 32'h1010_1010, 1'b0);
        wait_idle();

        // inverted region at frame end: flag set, ratio 0, the carried count kept;
        // spare register slots written and ignored
        apply_setup(13'd60, 13'd50, 13'd7, 13'd3, 32'h0000_0000, 8'd0);
        apb_write(REG_SPARE_LO, 32'hFFFF_FFFF);
        apb_write(REG_SPARE_HI, 32'hFFFF_FFFF);
        push_pixel(12'd60, 12'd7, 32'h0000_0000, 1'b1);
        wait_idle();

        // random phases: each a fresh setup and idle pattern, a few frames,
        // sometimes an open frame left for the next setup
        while (pixels_sent < 18 + RANDOM_PIXELS)
        begin
            random_setup();
            pixel_idle_mode   = $urandom_range(2, 0);
            result_stall_mode = $urandom_range(2, 0);
            repeat ($urandom_range(8, 2)) push_random_frame(1'b1);
            if ($urandom_range(99, 0) < 20)
                push_random_frame(1'b0);
            wait_idle();
        end
        push_random_pixel(1'b1);
        wait_idle();

        $display("covered %0d pixels, %0d frame summaries, %0d register setups",
                 pixels_sent, frames_checked, setups_applied);
        $display("frames with empty region %0d, with ratio at one %0d, mismatches %0d",
                 frames_empty, frames_saturated, mismatches);
        if (mismatches == 0 && frame_stats_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
rtl/rcmr_pkg.sv
rtl/rcmr_cfg.sv
rtl/rcmr_front.sv
rtl/rcmr_queue.sv
rtl/rcmr_div.sv
rtl/roi_color_match_ratio.sv
test/tb_top.sv
